FILE: hdl/granular_pitch_shifter_unit_defines.svh
// Assertion macros shared by the pitch shifter RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef GRANULAR_PITCH_SHIFTER_UNIT_DEFINES_SVH
`define GRANULAR_PITCH_SHIFTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define GPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define GPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/gps_pkg.sv
// Shared constants and register codes for the granular pitch shifter.
// No dependencies; imported by gps_ram and granular_pitch_shifter_unit.
package gps_pkg;

    localparam int GRAIN_LEN_DEF   = 256;
    localparam int DELAY_DEPTH_DEF = 1024;

    localparam int SAMPLE_W = 16;
    localparam int RATIO_W  = 16;
    localparam int COEFF_W  = 13;

    // Configuration register indexes
    typedef enum logic {
        CFG_TARGET_RATIO    = 1'b0,
        CFG_SMOOTHING_COEFF = 1'b1
    } t_cfg_idx;

    localparam logic [RATIO_W-1:0] RATIO_RST = 16'd16384;
    localparam logic [COEFF_W-1:0] COEFF_RST = 13'd1522;
    localparam logic [RATIO_W-1:0] RATIO_LO  = 16'd8192;
    localparam logic [RATIO_W-1:0] RATIO_HI  = 16'd32768;
    localparam logic [COEFF_W-1:0] COEFF_LO  = 13'd262;
    localparam logic [COEFF_W-1:0] COEFF_HI  = 13'd6291;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

endpackage

FILE: hdl/granular_pitch_shifter_unit.sv
// Granular pitch shifter, four Hann-windowed grains over a circular delay line.
// Each input word runs through setup, four grains of multiplier/RAM sequencing,
// a restoring divide and the output steps before the next word is taken; the
// single shared multiplier and the one RAM read port set this pace, and a stalled
// output word holds the input off. After reset a clearing pass writes zeros over
// the delay line, one entry a cycle (max(DELAY_DEPTH, 2*GRAIN_LEN) entries).
`include "granular_pitch_shifter_unit_defines.svh"

module granular_pitch_shifter_unit #(
    parameter int GRAIN_LEN   = gps_pkg::GRAIN_LEN_DEF,
    parameter int DELAY_DEPTH = gps_pkg::DELAY_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream; tdata: sample_in [15:0]
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [gps_pkg::SAMPLE_W-1:0]   i_s_tdata,
    // Output stream; tdata: sample_out [15:0]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [gps_pkg::SAMPLE_W-1:0]   o_m_tdata,
    // Configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [gps_pkg::RATIO_W-1:0]    i_cfg_data
);
    import gps_pkg::*;

    localparam int BUF_LEN = (DELAY_DEPTH > 2 * GRAIN_LEN) ? DELAY_DEPTH : 2 * GRAIN_LEN;
    localparam int AW      = $clog2(BUF_LEN);
    localparam int PW      = $clog2(GRAIN_LEN);
    localparam logic [63:0] GM1 = 64'(GRAIN_LEN - 1);

    localparam int G12     = GRAIN_LEN * 4096;
    localparam int MINB_R  = (G12 * 45) / 100;
    localparam int MIN_B0  = (MINB_R < 24 * 4096) ? 24 * 4096 : MINB_R;
    localparam int NAT0    = (G12 * 155) / 100;
    localparam int MAXB0   = (BUF_LEN - 6) * 4096;
    localparam int SPR_R   = (G12 * 55) / 1000;
    localparam int SPREAD  = (SPR_R < 2 * 4096) ? 2 * 4096 :
                             ((SPR_R > 24 * 4096) ? 24 * 4096 : SPR_R);
    localparam int DMIN    = 4096;
    localparam int DMAX    = (BUF_LEN - 2) * 4096;
    localparam int BUF12   = BUF_LEN * 4096;

    localparam logic signed [31:0] OFFS [4] = '{
        32'((SPREAD * -45) / 100), 32'((SPREAD * 18) / 100),
        32'((SPREAD * 62) / 100), 32'((SPREAD * -12) / 100)
    };

    typedef logic [15:0] t_hann [GRAIN_LEN];

    // sin(pi*u), u and result in Q30
    function automatic logic [63:0] sin_pi_q30(input logic [63:0] u_in);
        logic [63:0] u, x, x2, t;
        u  = (u_in > 64'(1 << 29)) ? (64'(1) << 30) - u_in : u_in;
        x  = (u * 64'd3373259426) >> 30;
        x2 = (x * x) >> 30;
        t  = (64'(1) << 30) - x2 / 72;
        t  = (64'(1) << 30) - ((x2 * t) >> 30) / 42;
        t  = (64'(1) << 30) - ((x2 * t) >> 30) / 20;
        t  = (64'(1) << 30) - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    function automatic t_hann gen_hann();
        t_hann       rom;
        logic [63:0] u, s, w;
        for (int n = 0; n < GRAIN_LEN; n++) begin
            u = (64'(n) << 30) / GM1;
            s = sin_pi_q30(u);
            w = (s * s) >> 30;
            rom[n] = 16'((w + 64'(1 << 14)) >> 15);
        end
        return rom;
    endfunction

    localparam t_hann HANN = gen_hann();

    typedef enum logic [20:0] {
        S_CLEAR = 21'h000001, S_IDLE  = 21'h000002, S_SMUL  = 21'h000004,
        S_SUPD  = 21'h000008, S_PDMUL = 21'h000010, S_BASE  = 21'h000020,
        S_BLEND = 21'h000040, S_GMUL  = 21'h000080, S_GDLY  = 21'h000100,
        S_GPOS  = 21'h000200, S_GRDA  = 21'h000400, S_GRDB  = 21'h000800,
        S_GIMUL = 21'h001000, S_GINT  = 21'h002000, S_GWMUL = 21'h004000,
        S_GACC  = 21'h008000, S_DSET  = 21'h010000, S_DIV   = 21'h020000,
        S_YMUL1 = 21'h040000, S_YMUL2 = 21'h080000, S_FIN   = 21'h100000
    } t_state;

    t_state                    r_state, n_state;
    logic [RATIO_W-1:0]        r_target;
    logic [COEFF_W-1:0]        r_coeff;
    logic [31:0]               r_ratio, n_ratio;
    logic [AW-1:0]             r_wp, r_clr;
    logic [PW-1:0]             r_phase [4];
    logic [1:0]                r_k;
    logic signed [15:0]        r_x, r_a, r_s, r_out;
    logic                      r_ovalid;
    logic signed [51:0]        r_prod, r_acc;
    logic signed [31:0]        r_base, r_d;
    logic [15:0]               r_blend;
    logic [AW-1:0]             r_ia, r_ib;
    logic [11:0]               r_frac;
    logic signed [33:0]        r_mixed;
    logic [17:0]               r_wsum;
    logic                      r_neg;
    logic [17:0]               r_rem;
    logic [16:0]               r_dq;
    logic [4:0]                r_cnt;

    logic signed [33:0]        mul_a;
    logic signed [17:0]        mul_b;
    logic [15:0]               tgt_c;
    logic [12:0]               coeff_c;
    logic [30:0]               absd;
    logic signed [33:0]        slope;
    logic [PW-1:0]             ph, ph_nx;
    logic [15:0]               w_cur;
    logic signed [15:0]        ram_rd;
    logic                      ram_we, ram_re;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [15:0]               ram_wdata;

    gps_ram #(.WIDTH(SAMPLE_W), .DEPTH(BUF_LEN)) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rd)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_out;

    // Clamp registers on use, derive common terms
    always_comb begin
        tgt_c   = (r_target < RATIO_LO) ? RATIO_LO : ((r_target > RATIO_HI) ? RATIO_HI : r_target);
        coeff_c = (r_coeff < COEFF_LO) ? COEFF_LO : ((r_coeff > COEFF_HI) ? COEFF_HI : r_coeff);
        absd    = (r_ratio >= ONE_Q30) ? 31'(r_ratio - ONE_Q30) : 31'(ONE_Q30 - r_ratio);
        slope   = 34'(signed'({2'b00, ONE_Q30})) - 34'(signed'({2'b00, r_ratio}));
        ph      = r_phase[r_k];
        ph_nx   = (ph == PW'(GRAIN_LEN - 1)) ? '0 : ph + 1'b1;
        w_cur   = HANN[ph];
    end

    // Shared multiplier operand select
    always_comb begin
        case (r_state)
            S_SMUL: begin
                mul_a = 34'(signed'({2'b00, tgt_c, 16'h0000})) - 34'(signed'({2'b00, r_ratio}));
                mul_b = 18'(signed'({1'b0, coeff_c}));
            end
            S_PDMUL: begin
                mul_a = 34'(signed'({3'b000, absd}));
                mul_b = 18'(GRAIN_LEN);
            end
            S_BASE: begin
                mul_a = 34'(signed'({3'b000, absd}));
                mul_b = 18'd36;
            end
            S_GMUL: begin
                mul_a = slope;
                mul_b = 18'(signed'({1'b0, ph}));
            end
            S_GIMUL: begin
                mul_a = 34'(ram_rd) - 34'(r_a);
                mul_b = 18'(signed'({1'b0, r_frac}));
            end
            S_GWMUL: begin
                mul_a = 34'(r_s);
                mul_b = 18'(signed'({1'b0, w_cur}));
            end
            S_YMUL1: begin
                if (r_wsum == '0) begin
                    mul_a = 34'(r_x);
                end else if (r_neg) begin
                    mul_a = -34'(signed'({1'b0, r_dq}));
                end else begin
                    mul_a = 34'(signed'({1'b0, r_dq}));
                end
                mul_b = 18'(signed'({1'b0, 17'd32768 - 17'(r_blend)}));
            end
            S_YMUL2, S_FIN: begin
                mul_a = 34'(r_x);
                mul_b = 18'(signed'({1'b0, r_blend}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Delay line ports: clearing sweep or sample write, grain reads
    always_comb begin
        ram_we    = (r_state == S_CLEAR) || (r_state == S_IDLE && i_s_tvalid);
        ram_waddr = (r_state == S_CLEAR) ? r_clr : r_wp;
        ram_wdata = (r_state == S_CLEAR) ? '0 : i_s_tdata;
        ram_re    = (r_state == S_GRDA) || (r_state == S_GRDB);
        ram_raddr = (r_state == S_GRDA) ? r_ia : r_ib;
    end

    // Configuration writes, taken at any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= RATIO_RST;
            r_coeff  <= COEFF_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET_RATIO:    r_target <= i_cfg_data;
                CFG_SMOOTHING_COEFF: r_coeff  <= i_cfg_data[COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Next-state and smoothed ratio
    always_comb begin
        n_state = r_state;
        n_ratio = 32'(34'(signed'({2'b00, r_ratio})) + 34'(r_prod >>> 20));
        case (r_state)
            S_CLEAR: if (r_clr == AW'(BUF_LEN - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_s_tvalid) n_state = S_SMUL;
            S_SMUL:  n_state = S_SUPD;
            S_SUPD:  n_state = S_PDMUL;
            S_PDMUL: n_state = S_BASE;
            S_BASE:  n_state = S_BLEND;
            S_BLEND: n_state = S_GMUL;
            S_GMUL:  n_state = S_GDLY;
            S_GDLY:  n_state = S_GPOS;
            S_GPOS:  n_state = S_GRDA;
            S_GRDA:  n_state = S_GRDB;
            S_GRDB:  n_state = S_GIMUL;
            S_GIMUL: n_state = S_GINT;
            S_GINT:  n_state = S_GWMUL;
            S_GWMUL: n_state = S_GACC;
            S_GACC:  n_state = (r_k == 2'd3) ? S_DSET : S_GMUL;
            S_DSET:  n_state = S_DIV;
            S_DIV:   if (r_cnt == 5'd1) n_state = S_YMUL1;
            S_YMUL1: n_state = S_YMUL2;
            S_YMUL2: n_state = S_FIN;
            S_FIN:   if (!r_ovalid || i_m_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_wp     <= '0;
            r_ratio  <= ONE_Q30;
            r_k      <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_phase[k] <= PW'(k * (GRAIN_LEN / 4));
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_SUPD) begin
                r_ratio <= n_ratio;
            end
            if (r_state == S_GACC) begin
                r_phase[r_k] <= ph_nx;
                r_k          <= r_k + 1'b1;
            end
            // Load the next output word at the end, else drop it once taken
            if (r_state == S_FIN && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
                r_wp     <= (r_wp == AW'(BUF_LEN - 1)) ? '0 : r_wp + 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        logic signed [31:0] pd, minb, maxb, nat, dc, pos;
        logic signed [31:0] bl;
        logic signed [51:0] y;
        logic [18:0]        t;
        logic [32:0]        mag;
        r_prod <= 52'(mul_a) * 52'(mul_b);
        pd   = 32'(r_prod >>> 18);
        minb = 32'(MIN_B0) + pd;
        maxb = 32'(MAXB0) - pd;
        if (maxb < minb) maxb = minb;
        nat  = 32'(NAT0) + pd;
        dc   = (r_d < 32'(DMIN)) ? 32'(DMIN) : ((r_d > 32'(DMAX)) ? 32'(DMAX) : r_d);
        pos  = 32'(signed'({1'b0, r_wp, 12'h000})) - dc;
        if (pos < 0) pos = pos + 32'(BUF12);
        bl   = 32'sd32768 - 32'(r_prod >>> 15);
        t    = {r_rem, r_dq[16]};
        mag  = r_mixed[33] ? 33'(-r_mixed) : 33'(r_mixed);
        y    = (r_acc + r_prod) >>> 15;
        case (r_state)
            S_IDLE:  r_x <= i_s_tdata;
            S_BASE:  r_base <= (nat < minb) ? minb : ((nat > maxb) ? maxb : nat);
            S_BLEND: begin
                r_blend <= (bl < 0) ? '0 : 16'(bl);
                r_mixed <= '0;
                r_wsum  <= '0;
            end
            S_GDLY:  r_d <= r_base + 32'(r_prod >>> 18) + OFFS[r_k];
            S_GPOS: begin
                r_ia   <= pos[AW+11:12];
                r_ib   <= (pos[AW+11:12] == AW'(BUF_LEN - 1)) ? '0 : pos[AW+11:12] + 1'b1;
                r_frac <= pos[11:0];
            end
            S_GRDB:  r_a <= ram_rd;
            S_GINT:  r_s <= 16'(34'(r_a) + 34'(r_prod >>> 12));
            S_GACC: begin
                r_mixed <= r_mixed + 34'(r_prod);
                r_wsum  <= r_wsum + 18'(w_cur);
            end
            S_DSET: begin
                r_neg <= r_mixed[33];
                r_rem <= 18'(mag[32:17]);
                r_dq  <= mag[16:0];
                r_cnt <= 5'd17;
            end
            S_DIV: begin
                // One restoring quotient bit per cycle
                if (t >= {1'b0, r_wsum}) begin
                    r_rem <= 18'(t - {1'b0, r_wsum});
                    r_dq  <= {r_dq[15:0], 1'b1};
                end else begin
                    r_rem <= t[17:0];
                    r_dq  <= {r_dq[15:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
            end
            S_YMUL2: r_acc <= r_prod;
            S_FIN: begin
                if (!r_ovalid || i_m_tready) begin
                    r_out <= (y > 52'sd32767) ? 16'sh7fff :
                             ((y < -52'sd32768) ? 16'sh8000 : 16'(y));
                end
            end
            default: ;
        endcase
    end

    `GPS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_state == S_SMUL, "accepted word did not start smoothing")
    `GPS_ASSERT_NOW(a_ratio_range, i_clk, i_rst_n, r_state != S_CLEAR, r_ratio >= 32'h2000_0000 && r_ratio <= 32'h8000_0000, "smoothed ratio left its range")
    `GPS_ASSERT_NOW(a_grains_done, i_clk, i_rst_n, r_state == S_DSET, r_k == 2'd0, "grain counter not wrapped at divide")
    `GPS_ASSERT_NOW(a_no_clear_accept, i_clk, i_rst_n, r_state == S_CLEAR, !o_s_tready, "input taken during clearing pass")

endmodule

FILE: hdl/gps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Takes its parameter defaults (WIDTH, DEPTH) from gps_pkg.
module gps_ram #(
    parameter int WIDTH = gps_pkg::SAMPLE_W,
    parameter int DEPTH = gps_pkg::DELAY_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    import gps_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/sv/granular_pitch_shifter_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for granular_pitch_shifter_unit: stream stimulus, random stalls,
// config sweeps and a bit-exact pitch-shift predictor. Depends on gps_pkg and the RTL.
module granular_pitch_shifter_unit_tb;
    import gps_pkg::*;

    localparam int GRAIN = GRAIN_LEN_DEF;
    localparam int BUFN  = (DELAY_DEPTH_DEF > 2 * GRAIN_LEN_DEF) ?
                           DELAY_DEPTH_DEF : 2 * GRAIN_LEN_DEF;
    localparam longint ONE = 64'sd1 << 30;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [SAMPLE_W-1:0] i_s_tdata = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [SAMPLE_W-1:0] o_m_tdata;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = 1'b0;
    logic [RATIO_W-1:0]  i_cfg_data = '0;

    granular_pitch_shifter_unit uut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic signed [15:0] line_mem [BUFN];
    int                 wr_ptr;
    longint             ratio_q30;
    int                 phase [4];
    longint             hann [GRAIN];
    logic [15:0]        tgt_reg;
    logic [12:0]        coeff_reg;
    longint             grain_pct [4] = '{-45, 18, 62, -12};

    logic [15:0] pending_out [$];
    int          err_count = 0;
    int          sent_count = 0;
    int          long_hold = 0;
    bit          quiet = 1'b0;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic longint tap_read(longint d);
        longint pos, a, b, frac;
        int ia, ib;
        if (d < (64'sd1 << 12)) d = 64'sd1 << 12;
        if (d > (longint'(BUFN - 2) << 12)) d = longint'(BUFN - 2) << 12;
        pos = (longint'(wr_ptr) << 12) - d;
        if (pos < 0) pos += longint'(BUFN) << 12;
        ia = int'(pos >>> 12) % BUFN;
        ib = (ia + 1) % BUFN;
        frac = pos & 4095;
        a = line_mem[ia];
        b = line_mem[ib];
        return a + (((b - a) * frac) >>> 12);
    endfunction

    // Advance the predictor by one sample and return the expected output word
    function automatic logic [15:0] shift_sample(logic signed [15:0] xin);
        longint x, tgt, cf, absd, pd, g12, min_b, max_b, nat, base;
        longint slope, spread, mixed, wsum, shifted, blend, y, w, off, d;
        x = xin;
        line_mem[wr_ptr] = xin;
        tgt = tgt_reg < 8192 ? 8192 : (tgt_reg > 32768 ? 32768 : tgt_reg);
        tgt = tgt << 16;
        cf = coeff_reg < 262 ? 262 : (coeff_reg > 6291 ? 6291 : coeff_reg);
        ratio_q30 += ((tgt - ratio_q30) * cf) >>> 20;
        absd = ratio_q30 >= ONE ? ratio_q30 - ONE : ONE - ratio_q30;
        pd = (absd * GRAIN) >>> 18;
        g12 = longint'(GRAIN) << 12;
        min_b = (g12 * 45) / 100;
        if (min_b < (64'sd24 << 12)) min_b = 64'sd24 << 12;
        min_b += pd;
        max_b = (longint'(BUFN - 6) << 12) - pd;
        if (max_b < min_b) max_b = min_b;
        nat = (g12 * 155) / 100 + pd;
        base = nat < min_b ? min_b : (nat > max_b ? max_b : nat);
        slope = ONE - ratio_q30;
        spread = (g12 * 55) / 1000;
        if (spread < (64'sd2 << 12)) spread = 64'sd2 << 12;
        if (spread > (64'sd24 << 12)) spread = 64'sd24 << 12;
        mixed = 0;
        wsum = 0;
        for (int k = 0; k < 4; k++) begin
            w = hann[phase[k]];
            off = (spread * grain_pct[k]) / 100;
            d = base + ((slope * phase[k]) >>> 18) + off;
            mixed += tap_read(d) * w;
            wsum += w;
            phase[k] = (phase[k] + 1) % GRAIN;
        end
        // Fall back to the dry input when the window sum vanishes
        shifted = wsum > 0 ? mixed / wsum : x;
        blend = 32768 - ((absd * 36) >>> 15);
        if (blend < 0) blend = 0;
        y = (shifted * (32768 - blend) + x * blend) >>> 15;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        wr_ptr = (wr_ptr + 1) % BUFN;
        return y[15:0];
    endfunction

    // Compare each output word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_out.size() == 0)
                report_mismatch("unexpected word", o_m_tdata, 16'h0);
            else
                if (o_m_tdata !== pending_out[0])
                    report_mismatch("sample_out", o_m_tdata, pending_out[0]);
            if (pending_out.size() != 0) void'(pending_out.pop_front());
        end
    end

    // Drive output ready: long holds, random stall bursts, or always ready
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold > 0) begin
                long_hold--;
                i_m_tready <= 1'b0;
            end else if (quiet) begin
                i_m_tready <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 8);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [15:0] x);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= x;
        do @(posedge i_clk); while (!o_s_tready);
        pending_out.push_back(shift_sample(x));
        sent_count++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else if (quiet) begin
            // stay valid; caller lowers it at the end
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [15:0] val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TARGET_RATIO) tgt_reg = val;
        else coeff_reg = val[12:0];
    endtask

    task automatic test_reset_defaults();
        foreach (line_mem[n]) line_mem[n] = '0;
        wr_ptr = 0;
        ratio_q30 = ONE;
        foreach (phase[k]) phase[k] = k * (GRAIN / 4);
        tgt_reg = RATIO_RST;
        coeff_reg = COEFF_RST;
        // Hann ROM from the integer sine series
        for (int n = 0; n < GRAIN; n++) begin
            longint unsigned u, x, x2, t, s, w;
            u = (longint'(n) << 30) / longint'(GRAIN - 1);
            if (u > (64'd1 << 29)) u = (64'd1 << 30) - u;
            x = (u * PI_Q30) >> 30;
            x2 = (x * x) >> 30;
            t = (64'd1 << 30) - x2 / 72;
            t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
            t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
            t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
            s = (x * t) >> 30;
            w = (s * s) >> 30;
            hann[n] = longint'((w + (64'd1 << 14)) >> 15);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Defaults, unity ratio: full-scale extremes pass straight through
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
    endtask

    task automatic test_config_extremes();
        logic [15:0] ratios [6] = '{16'd8192, 16'd32768, 16'd0, 16'hFFFF, 16'd16385, 16'd24576};
        logic [15:0] coeffs [4] = '{16'd262, 16'd6291, 16'd0, 16'hFFFF};
        for (int i = 0; i < 6; i++) begin
            write_cfg(CFG_TARGET_RATIO, ratios[i]);
            write_cfg(CFG_SMOOTHING_COEFF, coeffs[i % 4]);
            send_sample(16'h7FFF);
            send_sample(16'h8000);
            send_sample(16'($urandom));
        end
    endtask

    task automatic test_random_phases(input int n_phases, input int per_phase);
        for (int p = 0; p < n_phases; p++) begin
            case ($urandom_range(0, 3))
                0: write_cfg(CFG_TARGET_RATIO, 16'($urandom_range(8192, 32768)));
                1: write_cfg(CFG_TARGET_RATIO, $urandom_range(0, 1) ? RATIO_LO : RATIO_HI);
                2: write_cfg(CFG_TARGET_RATIO, 16'($urandom));
                default: write_cfg(CFG_TARGET_RATIO, 16'($urandom_range(16000, 16800)));
            endcase
            write_cfg(CFG_SMOOTHING_COEFF, $urandom_range(0, 3) == 0 ?
                      16'($urandom) : 16'($urandom_range(262, 6291)));
            for (int i = 0; i < per_phase; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_sample($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
                else
                    send_sample(16'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        long_hold = 600;
        for (int i = 0; i < 20; i++) send_sample(16'($urandom));
        // Sender pauses until every output has come back
        wait_drained();
    endtask

    initial begin
        test_reset_defaults();
        test_config_extremes();
        test_random_phases(7, 250);
        test_backpressure();
        quiet = 1'b1;
        test_random_phases(1, 250);
        wait_drained();
        $display("Covered %0d samples over ratio/coefficient sweeps incl. clamped values,",
                 sent_count);
        $display("full-scale inputs, random stalls and a long output hold-off.");
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout waiting for the pipeline");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: files.f
+incdir+hdl
hdl/gps_pkg.sv
hdl/gps_ram.sv
hdl/granular_pitch_shifter_unit.sv
tb/sv/granular_pitch_shifter_unit_tb.sv
